// File: rtl/core/tdpc_pkg.sv
package tdpc_pkg;

	localparam int PRESS_COUNT_BITS_DEF = 20;

	localparam int DEBOUNCE_W = 16;
	localparam int TICKS_W    = 20;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [TICKS_W-1:0]    SHORT_RST    = 20'd500;
	localparam logic [TICKS_W-1:0]    LONG_RST     = 20'd1000;
	localparam logic [TICKS_W-1:0]    FACTORY_RST  = 20'd10000;

	localparam logic [DEBOUNCE_W-1:0] STABLE_MAX = '1;
	localparam logic [TICKS_W-1:0]    TICKS_MAX  = '1;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_SHORT   = 2'd1,
		EV_LONG    = 2'd2,
		EV_FACTORY = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_SHORT    = 2'd1,
		REG_LONG     = 2'd2,
		REG_FACTORY  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ticks;
		logic [TICKS_W-1:0]    short_max_ticks;
		logic [TICKS_W-1:0]    long_min_ticks;
		logic [TICKS_W-1:0]    factory_min_ticks;
	} cfg_t;

endpackage

// File: rtl/core/tdpc_regs.sv
module tdpc_regs
	import tdpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= DEBOUNCE_RST;
			cfg_q.short_max_ticks   <= SHORT_RST;
			cfg_q.long_min_ticks    <= LONG_RST;
			cfg_q.factory_min_ticks <= FACTORY_RST;
		end else if (wr_en) begin
			case (idx)
				REG_DEBOUNCE: cfg_q.debounce_ticks    <= pwdata[DEBOUNCE_W-1:0];
				REG_SHORT:    cfg_q.short_max_ticks   <= pwdata[TICKS_W-1:0];
				REG_LONG:     cfg_q.long_min_ticks    <= pwdata[TICKS_W-1:0];
				REG_FACTORY:  cfg_q.factory_min_ticks <= pwdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEBOUNCE: prdata = APB_DATA_W'(cfg_q.debounce_ticks);
			REG_SHORT:    prdata = APB_DATA_W'(cfg_q.short_max_ticks);
			REG_LONG:     prdata = APB_DATA_W'(cfg_q.long_min_ticks);
			REG_FACTORY:  prdata = APB_DATA_W'(cfg_q.factory_min_ticks);
			default:      prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/touch_debounce_press_classifier.sv
// Touch debounce and press classifier. Each input transfer is one time-base tick carrying the
// raw touch level in s_tdata[0]; each tick produces exactly one output transfer with
// event_code in m_tdata[1:0] (0 none, 1 short, 2 long, 3 factory reset), the debounced level
// in m_tdata[2] and the current press length in m_tdata[22:3]. The tick logic is a single
// pass of counters and compares into one output register, so the block takes one tick per
// clock cycle; s_tready drops only while a finished result waits and m_tready is low. The
// four thresholds live in the APB registers at byte addresses 0, 4, 8 and 12 and should be
// written between ticks.
module touch_debounce_press_classifier
	import tdpc_pkg::*;
#(
	parameter int PRESS_COUNT_BITS = PRESS_COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] raw_touch
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [1:0] event_code, [2] touching, [22:3] press_ticks
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CW = PRESS_COUNT_BITS;
	localparam int CMP_W = (CW > TICKS_W) ? CW : TICKS_W;
	localparam logic [CW-1:0] CNT_MAX = '1;

	cfg_t cfg;

	tdpc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// tick state
	logic                  last_raw_q;
	logic [DEBOUNCE_W-1:0] stable_q;
	logic                  deb_q;
	logic                  active_q;
	logic [CW-1:0]         cnt_q;
	logic                  long_fired_q;
	logic                  reset_fired_q;

	// output register
	logic                  out_valid_q;
	event_t                ev_q;
	logic                  touching_q;
	logic [TICKS_W-1:0]    ticks_q;

	logic                  raw;
	logic                  accept;
	logic [DEBOUNCE_W-1:0] stable_n;
	logic                  deb_n;
	logic                  active_n;
	logic [CW-1:0]         cnt_inc;
	logic [CW-1:0]         cnt_n;
	logic                  long_n;
	logic                  reset_n;
	event_t                ev_n;
	logic [CMP_W-1:0]      cnt_wide;
	logic [CMP_W-1:0]      len_wide;
	logic [TICKS_W-1:0]    shown;

	assign raw      = s_tdata[0];
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign cnt_inc  = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign len_wide = CMP_W'(cnt_inc);

	always_comb begin
		ev_n     = EV_NONE;
		active_n = active_q;
		cnt_n    = cnt_q;
		long_n   = long_fired_q;
		reset_n  = reset_fired_q;

		if (raw != last_raw_q)
			stable_n = '0;
		else if (stable_q != STABLE_MAX)
			stable_n = stable_q + 1'b1;
		else
			stable_n = stable_q;

		deb_n = (stable_n >= cfg.debounce_ticks) ? raw : deb_q;

		if (deb_n != deb_q) begin
			if (deb_n) begin
				active_n = 1'b1;
				cnt_n    = '0;
				long_n   = 1'b0;
				reset_n  = 1'b0;
			end else begin
				// release: length counts the falling tick too
				if (active_q && !long_fired_q && !reset_fired_q &&
				    len_wide < CMP_W'(cfg.short_max_ticks))
					ev_n = EV_SHORT;
				active_n = 1'b0;
				cnt_n    = '0;
			end
		end else if (deb_n && active_q) begin
			cnt_n = cnt_inc;
		end

		cnt_wide = CMP_W'(cnt_n);

		if (deb_n && active_n) begin
			if (cnt_wide >= CMP_W'(cfg.factory_min_ticks) && !reset_n) begin
				reset_n = 1'b1;
				long_n  = 1'b1;
				ev_n    = EV_FACTORY;
			end else if (cnt_wide >= CMP_W'(cfg.long_min_ticks) && !long_n) begin
				long_n = 1'b1;
				ev_n   = EV_LONG;
			end
		end

		if (!active_n)
			shown = '0;
		else if (cnt_wide > CMP_W'(TICKS_MAX))
			shown = TICKS_MAX;
		else
			shown = cnt_wide[TICKS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			stable_q      <= '0;
			deb_q         <= 1'b0;
			active_q      <= 1'b0;
			cnt_q         <= '0;
			long_fired_q  <= 1'b0;
			reset_fired_q <= 1'b0;
		end else if (accept) begin
			last_raw_q    <= raw;
			stable_q      <= stable_n;
			deb_q         <= deb_n;
			active_q      <= active_n;
			cnt_q         <= cnt_n;
			long_fired_q  <= long_n;
			reset_fired_q <= reset_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q       <= ev_n;
			touching_q <= deb_n;
			ticks_q    <= shown;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, ticks_q, touching_q, ev_q};

endmodule
